@@ rtl/lwpc_pkg.sv @@
// Shared types and constants for the link watchdog power cycler.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package lwpc_pkg;

    localparam int CFG_W   = 24;
    localparam int FAIL_W  = 8;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_PERIOD_NORMAL     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_PERIOD_ALTERNATE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_FAIL_LIMIT        = 3'd2;
    localparam logic [ADDR_W-1:0] REG_POWER_CYCLE_TICKS = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LED_PULSE_TICKS   = 3'd4;

    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_PING  = 2'd1;
    localparam logic [1:0] PH_HELD  = 2'd2;
    localparam logic [1:0] PH_CYCLE = 2'd3;

    localparam logic CMD_TICK = 1'b0;

    typedef struct packed {
        logic [CFG_W-1:0]  period_normal;
        logic [CFG_W-1:0]  period_alternate;
        logic [FAIL_W-1:0] fail_limit;
        logic [CFG_W-1:0]  power_cycle_ticks;
        logic [CFG_W-1:0]  led_pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic command;
        logic button_pressed;
        logic ping_ok;
    } item_t;

    typedef struct packed {
        logic              relay_closed;
        logic              red_led;
        logic              green_led;
        logic              ping_request;
        logic              link_down;
        logic [FAIL_W-1:0] failure_count;
    } result_t;

endpackage

@@ rtl/lwpc_cfg.sv @@
// Configuration register bank for the link watchdog power cycler.
// Depends on lwpc_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module lwpc_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lwpc_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [lwpc_pkg::CFG_W-1:0]  cfg_wdata,
    output lwpc_pkg::cfg_t             cfg
);

    lwpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_normal     <= lwpc_pkg::CFG_W'(60);
            cfg_reg.period_alternate  <= lwpc_pkg::CFG_W'(300);
            cfg_reg.fail_limit        <= lwpc_pkg::FAIL_W'(3);
            cfg_reg.power_cycle_ticks <= lwpc_pkg::CFG_W'(10);
            cfg_reg.led_pulse_ticks   <= lwpc_pkg::CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                lwpc_pkg::REG_PERIOD_NORMAL:     cfg_reg.period_normal     <= cfg_wdata;
                lwpc_pkg::REG_PERIOD_ALTERNATE:  cfg_reg.period_alternate  <= cfg_wdata;
                lwpc_pkg::REG_FAIL_LIMIT:
                    cfg_reg.fail_limit <= cfg_wdata[lwpc_pkg::FAIL_W-1:0];
                lwpc_pkg::REG_POWER_CYCLE_TICKS: cfg_reg.power_cycle_ticks <= cfg_wdata;
                lwpc_pkg::REG_LED_PULSE_TICKS:   cfg_reg.led_pulse_ticks   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/lwpc_core.sv @@
// Watchdog state registers and the single-pass next-state logic for one beat.
// Depends on lwpc_pkg for phase codes, cfg_t, item_t and result_t.
`timescale 1ns / 1ps

module lwpc_core #(
    parameter int TIMER_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  lwpc_pkg::item_t     item,
    input  lwpc_pkg::cfg_t      cfg,
    output lwpc_pkg::result_t   result
);

    localparam int CMP_W = (TIMER_BITS > lwpc_pkg::CFG_W) ? TIMER_BITS : lwpc_pkg::CFG_W;

    logic [1:0]                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0]       period_timer_reg, period_timer_next;
    logic                        use_alt_reg, use_alt_next;
    logic [lwpc_pkg::FAIL_W-1:0] fail_reg, fail_next;
    logic [lwpc_pkg::CFG_W-1:0]  relay_timer_reg, relay_timer_next;
    logic [lwpc_pkg::CFG_W-1:0]  led_timer_reg, led_timer_next;
    logic                        red_reg, red_next;
    logic                        green_reg, green_next;
    logic                        request;
    logic [TIMER_BITS-1:0]       period_inc;
    logic [lwpc_pkg::CFG_W-1:0]  period_limit;
    logic [lwpc_pkg::CFG_W-1:0]  relay_dec;
    logic [lwpc_pkg::FAIL_W:0]   fail_plus;

    always_comb begin
        phase_next        = phase_reg;
        period_timer_next = period_timer_reg;
        use_alt_next      = use_alt_reg;
        fail_next         = fail_reg;
        relay_timer_next  = relay_timer_reg;
        led_timer_next    = led_timer_reg;
        red_next          = red_reg;
        green_next        = green_reg;
        request           = 1'b0;

        period_inc   = (&period_timer_reg) ? period_timer_reg
                                           : period_timer_reg + TIMER_BITS'(1);
        period_limit = use_alt_reg ? cfg.period_alternate : cfg.period_normal;
        relay_dec    = (relay_timer_reg != '0) ? relay_timer_reg - lwpc_pkg::CFG_W'(1) : '0;
        fail_plus    = {1'b0, fail_reg} + (lwpc_pkg::FAIL_W + 1)'(1);

        if (item.command == lwpc_pkg::CMD_TICK) begin
            if (led_timer_reg != '0) begin
                led_timer_next = led_timer_reg - lwpc_pkg::CFG_W'(1);
                if (led_timer_reg == lwpc_pkg::CFG_W'(1)) begin
                    green_next = 1'b1;
                end
            end
            if (phase_reg == lwpc_pkg::PH_CYCLE) begin
                relay_timer_next = relay_dec;
                if (relay_dec == '0) begin
                    use_alt_next      = 1'b1;
                    period_timer_next = '0;
                    phase_next        = lwpc_pkg::PH_WAIT;
                end
            end else if (phase_reg == lwpc_pkg::PH_HELD) begin
                if (!item.button_pressed) begin
                    if (cfg.power_cycle_ticks == '0) begin
                        relay_timer_next  = '0;
                        use_alt_next      = 1'b1;
                        period_timer_next = '0;
                        phase_next        = lwpc_pkg::PH_WAIT;
                    end else begin
                        relay_timer_next = cfg.power_cycle_ticks;
                        phase_next       = lwpc_pkg::PH_CYCLE;
                    end
                end
            end else if (item.button_pressed) begin
                fail_next      = cfg.fail_limit;
                red_next       = 1'b1;
                green_next     = 1'b0;
                led_timer_next = '0;
                phase_next     = lwpc_pkg::PH_HELD;
            end else if (phase_reg == lwpc_pkg::PH_WAIT) begin
                period_timer_next = period_inc;
                if (CMP_W'(period_inc) >= CMP_W'(period_limit)) begin
                    request    = 1'b1;
                    phase_next = lwpc_pkg::PH_PING;
                end
            end
        end else if (phase_reg == lwpc_pkg::PH_PING) begin
            if (item.ping_ok) begin
                fail_next         = '0;
                red_next          = 1'b0;
                led_timer_next    = cfg.led_pulse_ticks;
                green_next        = (cfg.led_pulse_ticks == '0);
                use_alt_next      = 1'b0;
                period_timer_next = '0;
                phase_next        = lwpc_pkg::PH_WAIT;
            end else if (fail_plus < {1'b0, cfg.fail_limit}) begin
                fail_next         = fail_plus[lwpc_pkg::FAIL_W-1:0];
                use_alt_next      = 1'b0;
                period_timer_next = '0;
                phase_next        = lwpc_pkg::PH_WAIT;
            end else begin
                fail_next      = cfg.fail_limit;
                red_next       = 1'b1;
                green_next     = 1'b0;
                led_timer_next = '0;
                if (cfg.power_cycle_ticks == '0) begin
                    relay_timer_next  = '0;
                    use_alt_next      = 1'b1;
                    period_timer_next = '0;
                    phase_next        = lwpc_pkg::PH_WAIT;
                end else begin
                    relay_timer_next = cfg.power_cycle_ticks;
                    phase_next       = lwpc_pkg::PH_CYCLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= lwpc_pkg::PH_WAIT;
            period_timer_reg <= '0;
            use_alt_reg      <= 1'b1;
            fail_reg         <= '0;
            relay_timer_reg  <= '0;
            led_timer_reg    <= '0;
            red_reg          <= 1'b0;
            green_reg        <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            period_timer_reg <= period_timer_next;
            use_alt_reg      <= use_alt_next;
            fail_reg         <= fail_next;
            relay_timer_reg  <= relay_timer_next;
            led_timer_reg    <= led_timer_next;
            red_reg          <= red_next;
            green_reg        <= green_next;
        end
    end

    always_comb begin
        result.relay_closed  = (phase_next != lwpc_pkg::PH_CYCLE);
        result.red_led       = red_next;
        result.green_led     = green_next;
        result.ping_request  = request;
        result.link_down     = (fail_next >= cfg.fail_limit);
        result.failure_count = fail_next;
    end

endmodule

@@ rtl/link_watchdog_power_cycler.sv @@
// Top level of the link watchdog power cycler: input register, core and result register.
// Depends on lwpc_pkg, lwpc_cfg and lwpc_core.
`timescale 1ns / 1ps

// Each input beat is either a time tick carrying the button level or a ping result, and
// each beat yields exactly one result beat with the relay, LED, ping request and failure
// state after that beat. A beat is captured in an input register and processed when it
// moves into the result register, which waits while the output is stalled; the block
// sustains one beat per cycle while the output is not stalled. The state registers of
// the core form the only loop. Configuration writes take effect at once and are expected
// only while no beats are in flight.
module link_watchdog_power_cycler #(
    parameter int TIMER_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lwpc_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [lwpc_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic                        s_button_pressed,
    input  logic                        s_ping_ok,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_relay_closed,
    output logic                        m_red_led,
    output logic                        m_green_led,
    output logic                        m_ping_request,
    output logic                        m_link_down,
    output logic [lwpc_pkg::FAIL_W-1:0] m_failure_count
);

    lwpc_pkg::cfg_t    cfg;
    lwpc_pkg::item_t   in_item_reg;
    lwpc_pkg::result_t result;
    lwpc_pkg::result_t out_reg;
    logic              in_vld_reg;
    logic              out_vld_reg;
    logic              advance;

    lwpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    lwpc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command        <= s_command;
            in_item_reg.button_pressed <= s_button_pressed;
            in_item_reg.ping_ok        <= s_ping_ok;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_relay_closed  = out_reg.relay_closed;
    assign m_red_led       = out_reg.red_led;
    assign m_green_led     = out_reg.green_led;
    assign m_ping_request  = out_reg.ping_request;
    assign m_link_down     = out_reg.link_down;
    assign m_failure_count = out_reg.failure_count;

    // A full pipeline with a stalled output must not take another beat.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_ready) |-> !s_ready)
        else $error("input beat accepted while both stages are full and stalled");

    // A power cycle only starts after the link has been marked down.
    a_cycle_red: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_relay_closed) |-> m_red_led)
        else $error("relay open while the red LED is off");

    // A check is only requested while the router is powered.
    a_request_powered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ping_request) |-> m_relay_closed)
        else $error("ping requested during a power cycle");

    // Marking the link down cancels any green pulse.
    a_red_green: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_red_led) |-> !m_green_led)
        else $error("green LED high while the red LED is lit");

endmodule
